FILE: hdl/tca_pkg.sv
// ----------------------------------------------------------------------------
// tca_pkg : shared types and constants for the ANSI colour text console
// Screen geometry, escape parser codes and the result transaction layout.
// ----------------------------------------------------------------------------
package tca_pkg;

    // Screen geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int IDX_W   = 11;
    localparam int CODE_W  = 10;

    // Character codes
    localparam logic [7:0] CHR_ESC   = 8'h1B;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_M     = 8'h6D;
    localparam logic [7:0] CHR_SEMI  = 8'h3B;
    localparam logic [7:0] CHR_BRACK = 8'h5B;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    // SGR codes and attribute values
    localparam logic [7:0]        ATTR_DEFAULT = 8'h0F;
    localparam logic [CODE_W-1:0] CODE_RESET   = 10'd0;
    localparam logic [CODE_W-1:0] CODE_FG_LO   = 10'd30;
    localparam logic [CODE_W-1:0] CODE_FG_HI   = 10'd37;
    localparam logic [CODE_W-1:0] CODE_MAX     = 10'd999;
    localparam logic [CODE_W-1:0] CODE_INVALID = 10'd1023;

    // Result kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // One result transaction
    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] cell_index;
        logic [7:0]       glyph;
        logic [7:0]       attribute;
        logic             last;
    } res_t;

    // ANSI colour number to console foreground nibble
    function automatic logic [3:0] fg_of_ansi(input logic [2:0] colour);
        logic [3:0] fg;
        unique case (colour)
            3'd0:    fg = 4'h0;
            3'd1:    fg = 4'h4;
            3'd2:    fg = 4'h2;
            3'd3:    fg = 4'hE;
            3'd4:    fg = 4'h1;
            3'd5:    fg = 4'h5;
            3'd6:    fg = 4'h3;
            default: fg = 4'hF;
        endcase
        return fg;
    endfunction

    // Apply one SGR code to the attribute
    function automatic logic [7:0] apply_code(input logic [7:0] attr,
                                              input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] colour;
        logic [7:0]        res;
        colour = code - CODE_FG_LO;
        res    = attr;
        if (code == CODE_RESET) begin
            res = ATTR_DEFAULT;
        end else if (code >= CODE_FG_LO && code <= CODE_FG_HI) begin
            res = {attr[7:4], fg_of_ansi(colour[2:0])};
        end
        return res;
    endfunction

endpackage

FILE: hdl/tca_core.sv
// ----------------------------------------------------------------------------
// tca_core : cursor, attribute and escape parser state
// Works out the results of one byte and updates the state when it is taken.
// ----------------------------------------------------------------------------
module tca_core
    import tca_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] byte_in,
    input  logic       step,
    output logic [1:0] res_count,
    output res_t       res0,
    output res_t       res1
);

    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [7:0]        attr_reg, attr_next;
    logic              esc_reg,  esc_next;
    logic [CODE_W-1:0] code_reg, code_next;

    // Per-byte decode
    always_comb begin
        logic [ROW_W-1:0]    nl_row;
        logic                nl_scroll;
        logic [7:0]          tab_x;
        logic                wrap;
        logic [COL_W-1:0]    wcol;
        logic [ROW_W-1:0]    wrow;
        logic [13:0]         acc;
        logic [3:0]          digit;
        res_t                scroll_res;
        res_t                write_res;

        col_next  = col_reg;
        row_next  = row_reg;
        attr_next = attr_reg;
        esc_next  = esc_reg;
        code_next = code_reg;
        res_count = 2'd0;
        res0      = '0;
        res1      = '0;

        // next line, with scroll on the last row
        nl_scroll = (row_reg >= ROW_W'(ROWS - 1));
        nl_row    = nl_scroll ? ROW_W'(ROWS - 1) : row_reg + ROW_W'(1);

        tab_x = 8'(((8'({1'b0, col_reg}) / 8'(TAB_STOP)) + 8'd1) * 8'(TAB_STOP));

        wrap = ({1'b0, col_reg} >= 8'(COLUMNS));
        wcol = wrap ? '0 : col_reg;
        wrow = wrap ? nl_row : row_reg;

        digit = 4'(byte_in - CHR_ZERO);
        acc   = 14'(code_reg) * 14'd10 + 14'(digit);

        scroll_res            = '0;
        scroll_res.kind       = KIND_SCROLL;
        scroll_res.last       = 1'b1;

        write_res             = '0;
        write_res.kind        = KIND_WRITE;
        write_res.cell_index  = IDX_W'(wcol) + IDX_W'(COLUMNS) * IDX_W'(wrow);
        write_res.glyph       = byte_in;
        write_res.attribute   = attr_reg;
        write_res.last        = 1'b1;

        if (esc_reg) begin
            // inside an SGR sequence
            if (byte_in == CHR_M || byte_in == CHR_SEMI) begin
                attr_next = apply_code(attr_reg, code_reg);
                code_next = '0;
                if (byte_in == CHR_M) begin
                    esc_next = 1'b0;
                end
            end else if (byte_in == CHR_BRACK) begin
                code_next = '0;
            end else if (byte_in >= CHR_ZERO && byte_in <= CHR_NINE
                         && code_reg <= CODE_MAX) begin
                code_next = (acc > 14'(CODE_MAX)) ? CODE_INVALID : acc[CODE_W-1:0];
            end else begin
                code_next = CODE_INVALID;
            end
        end else if (byte_in == CHR_ESC) begin
            esc_next = 1'b1;
        end else if (byte_in == CHR_TAB || byte_in == CHR_LF) begin
            if (byte_in == CHR_TAB && tab_x < 8'(COLUMNS)) begin
                col_next = tab_x[COL_W-1:0];
            end else begin
                col_next = '0;
                row_next = nl_row;
                if (nl_scroll) begin
                    res0      = scroll_res;
                    res_count = 2'd1;
                end
            end
        end else begin
            // printable: wrap first if the row is full
            row_next = wrow;
            col_next = wcol + COL_W'(1);
            if (wrap && nl_scroll) begin
                res0      = scroll_res;
                res0.last = 1'b0;
                res1      = write_res;
                res_count = 2'd2;
            end else begin
                res0      = write_res;
                res_count = 2'd1;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            attr_reg <= ATTR_DEFAULT;
            esc_reg  <= 1'b0;
            code_reg <= '0;
        end else if (step) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            attr_reg <= attr_next;
            esc_reg  <= esc_next;
            code_reg <= code_next;
        end
    end

endmodule

FILE: hdl/tca_outq.sv
// ----------------------------------------------------------------------------
// tca_outq : two-entry result queue
// Takes up to two results per cycle and hands them out one per transaction.
// ----------------------------------------------------------------------------
module tca_outq
    import tca_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_count,
    input  res_t       push0,
    input  res_t       push1,
    output logic [1:0] free,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       out_res
);

    res_t       entry_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;
    logic       wr_ptr;

    assign out_valid = (count_reg != 2'd0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign free      = 2'(3'd2 - 3'(count_reg) + 3'(pop));
    assign wr_ptr    = rd_ptr_reg ^ count_reg[0];

    // Pointer and fill level
    always_comb begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = 2'(3'(count_reg) + 3'(push_count) - 3'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entry_reg[wr_ptr] <= push0;
        end
        if (push_count == 2'd2) begin
            entry_reg[~wr_ptr] <= push1;
        end
    end

endmodule

FILE: hdl/text_console_ansi_color.sv
// ----------------------------------------------------------------------------
// text_console_ansi_color : 80x25 text console with ANSI SGR colour escapes
// Turns a byte stream into cell write and scroll commands.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the queue has room for the held
// byte's results. A byte passes through an input register, is decoded against
// the cursor and attribute state combinationally, and its results land in a
// two-entry output queue, so the first result is offered on the output once it
// has passed the input register and the queue. Most bytes give zero or one
// result and flow at one per cycle while m_ready is high; a printable byte
// that wraps on the last row gives a scroll and a write, which leave over two
// output transactions, the output port moving one result per cycle while
// m_ready is high. Escape bytes and tabs that stay on the row give no result.
module text_console_ansi_color
    import tca_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_byte_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_kind,
    output logic [IDX_W-1:0] m_cell_index,
    output logic [7:0]       m_glyph,
    output logic [7:0]       m_attribute,
    output logic             m_last
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic [1:0] res_count;
    logic [1:0] push_count;
    logic [1:0] free;
    logic       step;
    res_t       res0, res1, out_res;

    // The held byte moves on once the queue has room for all its results
    assign step       = in_valid_reg && (res_count <= free);
    assign push_count = step ? res_count : 2'd0;
    assign s_ready    = !in_valid_reg || step;

    // Input register
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !step);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
        end
    end

    tca_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_in   (in_byte_reg),
        .step      (step),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    tca_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .free       (free),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_res    (out_res)
    );

    assign m_kind       = out_res.kind;
    assign m_cell_index = out_res.cell_index;
    assign m_glyph      = out_res.glyph;
    assign m_attribute  = out_res.attribute;
    assign m_last       = out_res.last;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the ANSI colour text console
// A predictor follows the cursor, the colour attribute and the SGR parser for
// every byte taken in, and queues the cell writes and scrolls that the byte
// should give. Each result transaction is checked field by field against the
// oldest queued one. Stimulus opens with a short directed stream, then
// random text, tabs, newlines, long lines and SGR sequences, with both sides
// idling at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb_top;
    import tca_pkg::*;

    // Predictor and store of expected screen commands
    class console_tracker;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [7:0]        attr;
        bit                in_seq;
        logic [CODE_W-1:0] code;
        res_t              expected_cmds[$];
        int                errors;

        function new();
            col    = '0;
            row    = '0;
            attr   = ATTR_DEFAULT;
            in_seq = 1'b0;
            code   = '0;
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function logic [3:0] fg_nibble(int colour);
            case (colour)
                0:       return 4'h0;
                1:       return 4'h4;
                2:       return 4'h2;
                3:       return 4'hE;
                4:       return 4'h1;
                5:       return 4'h5;
                6:       return 4'h3;
                default: return 4'hF;
            endcase
        endfunction

        function void apply_sgr();
            if (code == CODE_RESET) begin
                attr = ATTR_DEFAULT;
            end else if (code >= CODE_FG_LO && code <= CODE_FG_HI) begin
                attr = {attr[7:4], fg_nibble(int'(code) - int'(CODE_FG_LO))};
            end
        endfunction

        // Next row, or a scroll when already on the bottom row
        function void feed_line();
            res_t r;
            col = '0;
            if (int'(row) + 1 >= ROWS) begin
                row = ROW_W'(ROWS - 1);
                r = '{KIND_SCROLL, '0, 8'h00, 8'h00, 1'b0};
                expected_cmds.push_back(r);
            end else begin
                row = row + 1'b1;
            end
        endfunction

        // Work out the commands for one accepted input transaction
        function void note_byte(logic [7:0] b);
            int   before_n;
            int   v;
            res_t r;
            before_n = expected_cmds.size();
            if (in_seq) begin
                if (b == CHR_M || b == CHR_SEMI) begin
                    apply_sgr();
                    code = '0;
                    if (b == CHR_M) in_seq = 1'b0;
                end else if (b == CHR_BRACK) begin
                    code = '0;
                end else if (b >= CHR_ZERO && b <= CHR_NINE && code <= CODE_MAX) begin
                    v = int'(code) * 10 + int'(b - CHR_ZERO);
                    code = (v > int'(CODE_MAX)) ? CODE_INVALID : CODE_W'(v);
                end else begin
                    code = CODE_INVALID;
                end
                return;
            end
            if (b == CHR_ESC) begin
                in_seq = 1'b1;
            end else if (b == CHR_TAB) begin
                v = (int'(col) / TAB_STOP + 1) * TAB_STOP;
                if (v >= COLUMNS) feed_line();
                else col = COL_W'(v);
            end else if (b == CHR_LF) begin
                feed_line();
            end else begin
                // full row wraps before the write
                if (int'(col) >= COLUMNS) feed_line();
                r = '{KIND_WRITE, IDX_W'(int'(col) + COLUMNS * int'(row)), b, attr, 1'b0};
                expected_cmds.push_back(r);
                col = col + 1'b1;
            end
            if (expected_cmds.size() > before_n) begin
                r = expected_cmds[expected_cmds.size() - 1];
                r.last = 1'b1;
                expected_cmds[expected_cmds.size() - 1] = r;
            end
        endfunction

        // Compare one result transaction with the oldest expectation
        task check_cmd(res_t got);
            res_t exp;
            if (expected_cmds.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d cell %0d glyph %02h",
                                          got.kind, got.cell_index, got.glyph));
                return;
            end
            exp = expected_cmds.pop_front();
            if (got.kind !== exp.kind)
                report_mismatch($sformatf("kind %0d, want %0d", got.kind, exp.kind));
            if (got.cell_index !== exp.cell_index)
                report_mismatch($sformatf("cell_index %0d, want %0d",
                                          got.cell_index, exp.cell_index));
            if (got.glyph !== exp.glyph)
                report_mismatch($sformatf("glyph %02h, want %02h", got.glyph, exp.glyph));
            if (got.attribute !== exp.attribute)
                report_mismatch($sformatf("attribute %02h, want %02h",
                                          got.attribute, exp.attribute));
            if (got.last !== exp.last)
                report_mismatch($sformatf("last %0d, want %0d", got.last, exp.last));
        endtask
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_byte_in = 8'h00;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_kind;
    logic [IDX_W-1:0] m_cell_index;
    logic [7:0]       m_glyph;
    logic [7:0]       m_attribute;
    logic             m_last;

    console_tracker screen = new();
    int send_idle  = 0;
    int recv_idle  = 0;
    int bytes_sent = 0;

    text_console_ansi_color uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_in    (s_byte_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_cell_index (m_cell_index),
        .m_glyph      (m_glyph),
        .m_attribute  (m_attribute),
        .m_last       (m_last)
    );

    always #6 aclk = ~aclk;

    // Receiver stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Transactions on both channels, sampled with pre-edge values
    always @(posedge aclk) begin
        res_t got;
        if (aresetn) begin
            if (s_valid && s_ready) screen.note_byte(s_byte_in);
            if (m_valid && m_ready) begin
                got = '{m_kind, m_cell_index, m_glyph, m_attribute, m_last};
                screen.check_cmd(got);
            end
        end
    end

    // One byte, with an optional random gap in front
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_literal(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic logic [7:0] printable_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CHR_ESC || b == CHR_TAB || b == CHR_LF);
        return b;
    endfunction

    // ESC [ n ; n m with random codes, now and then broken
    task automatic send_sgr();
        int n;
        int pick;
        int val;
        send_byte(CHR_ESC);
        if ($urandom_range(0, 9) != 0) send_byte(CHR_BRACK);
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) val = 0;
            else if (pick < 7) val = $urandom_range(30, 37);
            else if (pick < 9) val = $urandom_range(0, 999);
            else val = $urandom_range(1000, 99999);
            send_literal($sformatf("%0d", val));
            if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(0, 255)));
            send_byte((i == n - 1) ? CHR_M : CHR_SEMI);
        end
    endtask

    // Random segments until the byte count reaches the mark
    task automatic run_phase(input int upto);
        int seg;
        int n;
        while (bytes_sent < upto) begin
            seg = $urandom_range(0, 19);
            if (seg < 5) begin
                send_sgr();
            end else if (seg < 11) begin
                n = $urandom_range(1, 12);
                repeat (n) send_byte(printable_byte());
            end else if (seg < 14) begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(CHR_LF);
            end else if (seg < 16) begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(CHR_TAB);
            end else if (seg == 16) begin
                // long line, which can force a wrap
                n = $urandom_range(70, 90);
                repeat (n) send_byte(printable_byte());
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: byte extremes, tab, colour, overflowed code, ESC inside a
        // sequence, attribute reset, parser bytes outside a sequence, newline
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHR_TAB);
        send_byte(CHR_ESC);
        send_byte(CHR_BRACK);
        send_literal("31");
        send_byte(CHR_M);
        send_literal("B");
        send_byte(CHR_ESC);
        send_byte(CHR_BRACK);
        send_literal("9999");
        send_byte(CHR_SEMI);
        send_literal("37");
        send_byte(CHR_ESC);
        send_literal("1");
        send_byte(CHR_M);
        send_byte(CHR_M);
        send_byte(CHR_BRACK);
        send_byte(CHR_ESC);
        send_byte(CHR_BRACK);
        send_literal("0");
        send_byte(CHR_M);
        send_byte(CHR_LF);

        send_idle = 22;
        recv_idle = 62;
        run_phase(230);
        send_idle = 62;
        recv_idle = 22;
        run_phase(450);
        send_idle = 0;
        recv_idle = 0;
        run_phase(670);
        s_valid <= 1'b0;

        while (screen.expected_cmds.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (screen.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hdl/tca_pkg.sv
hdl/tca_core.sv
hdl/tca_outq.sv
hdl/text_console_ansi_color.sv
tb/tb_top.sv
